@@ src/svm_pkg.sv @@
package svm_pkg;

    localparam int unsigned VOICES = 8;
    localparam int unsigned EFFECTS = 16;
    localparam int unsigned SAMPLE_MEM_WORDS = 262144;
    localparam int unsigned FADE_FRAMES = 96;

    localparam int unsigned VOICE_W = $clog2(VOICES);
    localparam int unsigned SLOT_W = $clog2(EFFECTS);
    localparam int unsigned MEM_AW = $clog2(SAMPLE_MEM_WORDS);
    localparam int unsigned ADDR_W = 18;
    localparam int unsigned FRAMES_W = 19;
    localparam int unsigned GAIN_W = 9;
    localparam int unsigned FADE_W = $clog2(FADE_FRAMES + 1);
    localparam int unsigned ACC_W = 24;

    // Division of the fade product by FADE_FRAMES as a reciprocal multiply.
    // The rounded-up reciprocal is exact for products below 2^16.
    localparam int unsigned FADE_RECIP_SHIFT = 22;
    localparam int unsigned FADE_RECIP =
        ((1 << FADE_RECIP_SHIFT) + FADE_FRAMES - 1) / FADE_FRAMES;

    localparam logic [1:0] OP_PCM = 2'd0;
    localparam logic [1:0] OP_DESC = 2'd1;
    localparam logic [1:0] OP_TRIG = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    localparam logic [1:0] REG_VOICE_GAIN = 2'd0;
    localparam logic [1:0] REG_MUSIC_GAIN = 2'd1;
    localparam logic [1:0] REG_GUARD = 2'd2;

    localparam logic [GAIN_W-1:0] VOICE_GAIN_RST = 9'd72;
    localparam logic [GAIN_W-1:0] MUSIC_GAIN_RST = 9'd128;
    localparam logic [FRAMES_W-1:0] GUARD_RST = 19'd2048;

    typedef enum logic [3:0] {
        t_IDLE,
        t_TRIG_SCAN,
        t_MUSIC,
        t_V_DESC,
        t_V_CALC,
        t_V_RDL,
        t_V_RDR,
        t_V_MUL,
        t_V_ADD,
        t_SAT,
        t_OUT
    } t_state;

    // Sample memory request from the sequencer.
    typedef struct packed {
        logic              wr;
        logic              rd;
        logic [MEM_AW-1:0] addr;
        logic [15:0]       wdata;
    } t_mem_req;

endpackage

@@ src/svm_sample_ram.sv @@
module svm_sample_ram (
    input  logic                      i_clk,
    input  svm_pkg::t_mem_req         i_req,
    output logic signed [15:0]        o_rdata
);

    logic [15:0] mem [svm_pkg::SAMPLE_MEM_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            o_rdata <= mem[i_req.addr];
        end
    end

endmodule

@@ src/sample_voice_mixer.sv @@
// sample_voice_mixer: eight one-shot voices mixed with a music pair per tick.
// Pcm and descriptor items are absorbed at their accepting edge; a trigger item then scans the voices
// one by one; a tick item loads its music pair, walks each voice through its descriptor, address,
// read, multiply and add steps, then saturates and offers its frame. Throughput is one item at a
// time; a frame still waiting holds the next tick at its saturation step. Reset (synchronous, active
// low) clears voices, descriptor frame counts and stereo flags, and restores the default gains.
module sample_voice_mixer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [103:0] s_axis_tdata, // opcode, address, pcm_word, effect_id,
                                       // frame_count, stereo, music_left, music_right
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // out_left, out_right
    output logic        m_axis_tuser,  // clipped
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [18:0] i_cfg_wdata
);

    localparam int unsigned VW = svm_pkg::VOICE_W;
    localparam int unsigned SW = svm_pkg::SLOT_W;
    localparam int unsigned FW = svm_pkg::FRAMES_W;
    localparam int unsigned AW = svm_pkg::ACC_W;

    // Input fields.
    logic [1:0]         f_op;
    logic [17:0]        f_addr;
    logic [15:0]        f_pcm;
    logic [8:0]         f_eid;
    logic [FW-1:0]      f_frames;
    logic               f_stereo;
    assign f_op     = s_axis_tdata[1:0];
    assign f_addr   = s_axis_tdata[19:2];
    assign f_pcm    = s_axis_tdata[35:20];
    assign f_eid    = s_axis_tdata[44:36];
    assign f_frames = s_axis_tdata[63:45];
    assign f_stereo = s_axis_tdata[64];

    logic [8:0] eid_mag;
    assign eid_mag = f_eid[8] ? 9'(-f_eid) : f_eid;

    // Configuration registers.
    logic [8:0]    r_vgain, r_mgain;
    logic [FW-1:0] r_guard;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vgain <= svm_pkg::VOICE_GAIN_RST;
            r_mgain <= svm_pkg::MUSIC_GAIN_RST;
            r_guard <= svm_pkg::GUARD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                svm_pkg::REG_VOICE_GAIN: r_vgain <= i_cfg_wdata[8:0];
                svm_pkg::REG_MUSIC_GAIN: r_mgain <= i_cfg_wdata[8:0];
                svm_pkg::REG_GUARD:      r_guard <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Descriptor and voice tables (small, read at the sequencer's index).
    logic [17:0]   r_dbase   [svm_pkg::EFFECTS];
    logic [FW-1:0] r_dframes [svm_pkg::EFFECTS];
    logic          r_dstereo [svm_pkg::EFFECTS];
    logic          r_vact    [svm_pkg::VOICES];
    logic [SW-1:0] r_vsmp    [svm_pkg::VOICES];
    logic [FW-1:0] r_vpos    [svm_pkg::VOICES];

    svm_pkg::t_state r_state, n_state;
    logic [103:0]    r_item;
    logic [VW-1:0]   r_v;
    logic [VW:0]     r_free;      // first free voice, VOICES when none
    logic            r_block;
    logic signed [AW-1:0] r_accl, r_accr;
    logic [17:0]     r_base;
    logic [FW-1:0]   r_pos, r_frames;
    logic            r_st, r_live;
    logic [8:0]      r_gain;
    logic signed [15:0] r_sl, r_sr;
    logic signed [26:0] r_pl, r_pr;
    logic [15:0]     r_ol, r_or;
    logic            r_clip;
    logic            r_ovalid;

    // Music pair of the tick being mixed, scaled by the music gain.
    logic signed [15:0] f_ml_r, f_mr_r;
    logic signed [25:0] mus_l, mus_r;
    assign f_ml_r = r_item[80:65];
    assign f_mr_r = r_item[96:81];
    assign mus_l  = f_ml_r * $signed({1'b0, r_mgain});
    assign mus_r  = f_mr_r * $signed({1'b0, r_mgain});

    logic signed [15:0] ram_q;
    svm_pkg::t_mem_req  mem_req;

    svm_sample_ram u_ram (.i_clk(i_clk), .i_req(mem_req), .o_rdata(ram_q));

    logic [8:0] r_id;
    logic [SW-1:0] t_id;
    assign t_id = r_id[SW-1:0];

    assign s_axis_tready = (r_state == svm_pkg::t_IDLE);
    logic acc_in;
    assign acc_in = s_axis_tvalid && s_axis_tready;

    // The output register may be refilled once its frame is gone or leaves now.
    logic sat_go;
    assign sat_go = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            svm_pkg::t_IDLE:
                if (acc_in) begin
                    if (f_op == svm_pkg::OP_TRIG) n_state = svm_pkg::t_TRIG_SCAN;
                    else if (f_op == svm_pkg::OP_TICK) n_state = svm_pkg::t_MUSIC;
                end
            svm_pkg::t_TRIG_SCAN:
                if (r_v == VW'(svm_pkg::VOICES - 1)) n_state = svm_pkg::t_IDLE;
            svm_pkg::t_MUSIC:  n_state = svm_pkg::t_V_DESC;
            svm_pkg::t_V_DESC: n_state = svm_pkg::t_V_CALC;
            svm_pkg::t_V_CALC: n_state = svm_pkg::t_V_RDL;
            svm_pkg::t_V_RDL:  n_state = svm_pkg::t_V_RDR;
            svm_pkg::t_V_RDR:  n_state = svm_pkg::t_V_MUL;
            svm_pkg::t_V_MUL:  n_state = svm_pkg::t_V_ADD;
            svm_pkg::t_V_ADD:
                n_state = (r_v == VW'(svm_pkg::VOICES - 1)) ? svm_pkg::t_SAT
                                                           : svm_pkg::t_V_DESC;
            svm_pkg::t_SAT:    if (sat_go) n_state = svm_pkg::t_OUT;
            svm_pkg::t_OUT:    n_state = svm_pkg::t_IDLE;
            default:           n_state = svm_pkg::t_IDLE;
        endcase
    end

    // Memory addresses of the current voice frame.
    logic [17:0] a_l, a_r;
    assign a_l = r_st ? 18'(r_base + {r_pos[16:0], 1'b0}) : 18'(r_base + r_pos[17:0]);
    assign a_r = 18'(a_l + 18'd1);

    always_comb begin
        mem_req = '0;
        if (r_state == svm_pkg::t_IDLE && acc_in && f_op == svm_pkg::OP_PCM) begin
            mem_req.wr    = (32'(f_addr) < svm_pkg::SAMPLE_MEM_WORDS);
            mem_req.addr  = f_addr[svm_pkg::MEM_AW-1:0];
            mem_req.wdata = f_pcm;
        end else if (r_state == svm_pkg::t_V_CALC) begin
            mem_req.rd   = 1'b1;
            mem_req.addr = a_l[svm_pkg::MEM_AW-1:0];
        end else if (r_state == svm_pkg::t_V_RDL) begin
            mem_req.rd   = 1'b1;
            mem_req.addr = a_r[svm_pkg::MEM_AW-1:0];
        end
    end

    // Fade factor for the current voice; the divide by the fade length is a
    // multiply by its reciprocal.
    logic [FW-1:0] tail, fade_full;
    logic [svm_pkg::FADE_W-1:0] fade;
    logic [15:0]   gprod;
    logic [31:0]   gscaled;
    assign tail = r_frames - r_pos;
    always_comb begin
        fade_full = (r_pos < FW'(svm_pkg::FADE_FRAMES)) ? r_pos
                                                       : FW'(svm_pkg::FADE_FRAMES);
        if (tail < fade_full) fade_full = tail;
        fade    = fade_full[svm_pkg::FADE_W-1:0];
        gprod   = 16'(r_vgain * fade);
        gscaled = gprod * 16'(svm_pkg::FADE_RECIP);
    end

    logic signed [AW-1:0] sum_l, sum_r;
    assign sum_l = r_accl + AW'(r_pl >>> 8);
    assign sum_r = r_accr + AW'(r_pr >>> 8);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= svm_pkg::t_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < int'(svm_pkg::EFFECTS); i++) begin
                r_dframes[i] <= '0;
                r_dstereo[i] <= 1'b0;
            end
            for (int i = 0; i < int'(svm_pkg::VOICES); i++) begin
                r_vact[i] <= 1'b0;
                r_vsmp[i] <= '0;
                r_vpos[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == svm_pkg::t_OUT) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                svm_pkg::t_IDLE: begin
                    r_item  <= s_axis_tdata;
                    r_id    <= eid_mag;
                    r_v     <= '0;
                    r_free  <= (VW+1)'(svm_pkg::VOICES);
                    r_block <= 1'b0;
                    if (acc_in && f_op == svm_pkg::OP_DESC &&
                        eid_mag < 9'(svm_pkg::EFFECTS)) begin
                        r_dbase[eid_mag[SW-1:0]]   <= f_addr;
                        r_dframes[eid_mag[SW-1:0]] <= f_frames;
                        r_dstereo[eid_mag[SW-1:0]] <= f_stereo;
                    end
                end
                svm_pkg::t_TRIG_SCAN: begin
                    // One voice a cycle: guard check and first free voice.
                    if (r_vact[r_v] && r_vsmp[r_v] == t_id && r_vpos[r_v] < r_guard)
                        r_block <= 1'b1;
                    if (!r_vact[r_v] && r_free == (VW+1)'(svm_pkg::VOICES))
                        r_free <= {1'b0, r_v};
                    r_v <= r_v + 1'b1;
                    if (r_v == VW'(svm_pkg::VOICES - 1) && r_id < 9'(svm_pkg::EFFECTS) &&
                        r_dframes[t_id] != '0 &&
                        !(r_block || (r_vact[r_v] && r_vsmp[r_v] == t_id &&
                                      r_vpos[r_v] < r_guard))) begin
                        if (r_free != (VW+1)'(svm_pkg::VOICES)) begin
                            r_vact[r_free[VW-1:0]] <= 1'b1;
                            r_vsmp[r_free[VW-1:0]] <= t_id;
                            r_vpos[r_free[VW-1:0]] <= '0;
                        end else if (!r_vact[r_v]) begin
                            r_vact[r_v] <= 1'b1;
                            r_vsmp[r_v] <= t_id;
                            r_vpos[r_v] <= '0;
                        end else begin
                            r_vact[t_id[VW-1:0]] <= 1'b1;
                            r_vsmp[t_id[VW-1:0]] <= t_id;
                            r_vpos[t_id[VW-1:0]] <= '0;
                        end
                    end
                end
                svm_pkg::t_MUSIC: begin
                    r_accl <= AW'(mus_l >>> 8);
                    r_accr <= AW'(mus_r >>> 8);
                    r_v    <= '0;
                end
                svm_pkg::t_V_DESC: begin
                    r_base   <= r_dbase[r_vsmp[r_v]];
                    r_frames <= r_dframes[r_vsmp[r_v]];
                    r_st     <= r_dstereo[r_vsmp[r_v]];
                    r_pos    <= r_vpos[r_v];
                end
                svm_pkg::t_V_CALC: begin
                    r_live <= r_vact[r_v] && (r_pos < r_frames);
                    if (r_vact[r_v] && !(r_pos < r_frames)) r_vact[r_v] <= 1'b0;
                    r_gain <= (fade_full < FW'(svm_pkg::FADE_FRAMES))
                              ? 9'(gscaled >> svm_pkg::FADE_RECIP_SHIFT) : r_vgain;
                end
                svm_pkg::t_V_RDL: begin
                    r_sl <= (32'(a_l) >= svm_pkg::SAMPLE_MEM_WORDS) ? 16'sd0 : ram_q;
                end
                svm_pkg::t_V_RDR: begin
                    if (r_st) begin
                        r_sr <= (32'(a_r) >= svm_pkg::SAMPLE_MEM_WORDS) ? 16'sd0 : ram_q;
                    end else begin
                        r_sr <= r_sl;
                    end
                end
                svm_pkg::t_V_MUL: begin
                    r_pl <= r_sl * $signed({1'b0, r_gain});
                    r_pr <= r_sr * $signed({1'b0, r_gain});
                end
                svm_pkg::t_V_ADD: begin
                    if (r_live) begin
                        r_accl <= sum_l;
                        r_accr <= sum_r;
                        r_vpos[r_v] <= r_pos + 1'b1;
                    end
                    r_v <= r_v + 1'b1;
                end
                svm_pkg::t_SAT: begin
                    // The previous frame must be gone before its register is reused.
                    if (sat_go) begin
                        r_ol <= (r_accl > 24'sd32767) ? 16'h7FFF :
                                (r_accl < -24'sd32768) ? 16'h8000 : r_accl[15:0];
                        r_or <= (r_accr > 24'sd32767) ? 16'h7FFF :
                                (r_accr < -24'sd32768) ? 16'h8000 : r_accr[15:0];
                        r_clip <= (r_accl > 24'sd32767) || (r_accl < -24'sd32768) ||
                                  (r_accr > 24'sd32767) || (r_accr < -24'sd32768);
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_or, r_ol};
    assign m_axis_tuser  = r_clip;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != svm_pkg::t_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");
    a_out_after_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == svm_pkg::t_OUT))
        else $error("result without tick");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !m_axis_tready) |=> (r_ovalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");
`endif

endmodule

@@ tb/tb_sample_voice_mixer.sv @@
`timescale 1ns / 100ps

import svm_pkg::*;

// One mixed output frame as the block should produce it.
typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               clip;
} t_mix_frame;

// Scoreboard: keeps a private copy of the mixer state, predicts the frame of
// every accepted tick and compares each output frame with the oldest one due.
class mix_scoreboard;
    logic signed [15:0] pcm_mem [int];
    logic [17:0] d_base [EFFECTS];
    logic [18:0] d_frames [EFFECTS];
    logic        d_stereo [EFFECTS];
    logic        v_on [VOICES];
    logic [3:0]  v_smp [VOICES];
    logic [18:0] v_pos [VOICES];
    logic [8:0]  g_voice;
    logic [8:0]  g_music;
    logic [18:0] guard;
    t_mix_frame  frames_due [$];
    int          errors;
    int          frames_seen;
    int          clip_count;

    function new();
        for (int i = 0; i < EFFECTS; i++) begin
            d_base[i] = '0;
            d_frames[i] = '0;
            d_stereo[i] = 1'b0;
        end
        for (int v = 0; v < VOICES; v++) begin
            v_on[v] = 1'b0;
            v_smp[v] = '0;
            v_pos[v] = '0;
        end
        g_voice = VOICE_GAIN_RST;
        g_music = MUSIC_GAIN_RST;
        guard = GUARD_RST;
        errors = 0;
        frames_seen = 0;
        clip_count = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [18:0] val);
        case (idx)
            REG_VOICE_GAIN: g_voice = val[8:0];
            REG_MUSIC_GAIN: g_music = val[8:0];
            REG_GUARD:      guard = val;
            default: ;
        endcase
    endfunction

    function int read_word(logic [17:0] addr);
        if (pcm_mem.exists(addr)) return pcm_mem[addr];
        return 0;
    endfunction

    // Arithmetic shift gives floor division by 256.
    function int scale(int x, int g);
        int p;
        p = x * g;
        return p >>> 8;
    endfunction

    function void note_item(logic [1:0] op, logic [17:0] addr, logic signed [15:0] pcm,
                            logic signed [8:0] eid, logic [18:0] nfr, logic st,
                            logic signed [15:0] ml, logic signed [15:0] mr);
        int id;
        int l;
        int r;
        int slot;
        int s;
        int pos;
        int nf;
        int fade;
        int g;
        int vl;
        int vr;
        bit hit;
        t_mix_frame f;
        id = (eid < 0) ? -int'(eid) : int'(eid);
        case (op)
            OP_PCM: pcm_mem[addr] = pcm;
            OP_DESC: begin
                if (id < EFFECTS) begin
                    d_base[id] = addr;
                    d_frames[id] = nfr;
                    d_stereo[id] = st;
                end
            end
            OP_TRIG: begin
                if (id < EFFECTS && d_frames[id] != 0) begin
                    hit = 0;
                    for (int v = 0; v < VOICES; v++)
                        if (v_on[v] && v_smp[v] == id && v_pos[v] < guard) hit = 1;
                    if (!hit) begin
                        slot = -1;
                        for (int v = 0; v < VOICES; v++)
                            if (!v_on[v] && slot < 0) slot = v;
                        if (slot < 0) slot = id % VOICES;
                        v_on[slot] = 1'b1;
                        v_smp[slot] = id[3:0];
                        v_pos[slot] = '0;
                    end
                end
            end
            default: begin
                l = scale(ml, g_music);
                r = scale(mr, g_music);
                for (int v = 0; v < VOICES; v++) begin
                    if (!v_on[v]) continue;
                    s = v_smp[v];
                    pos = v_pos[v];
                    nf = d_frames[s];
                    if (pos >= nf) begin
                        v_on[v] = 1'b0;
                        continue;
                    end
                    if (d_stereo[s]) begin
                        vl = read_word(d_base[s] + 18'(2 * pos));
                        vr = read_word(d_base[s] + 18'(2 * pos + 1));
                    end else begin
                        vl = read_word(d_base[s] + 18'(pos));
                        vr = vl;
                    end
                    fade = (pos < FADE_FRAMES) ? pos : FADE_FRAMES;
                    if (nf - pos < fade) fade = nf - pos;
                    g = g_voice;
                    if (fade < FADE_FRAMES) g = (g_voice * fade) / FADE_FRAMES;
                    l += scale(vl, g);
                    r += scale(vr, g);
                    v_pos[v] = 19'(pos + 1);
                end
                f.clip = 1'b0;
                if (l > 32767) begin l = 32767; f.clip = 1'b1; end
                if (l < -32768) begin l = -32768; f.clip = 1'b1; end
                if (r > 32767) begin r = 32767; f.clip = 1'b1; end
                if (r < -32768) begin r = -32768; f.clip = 1'b1; end
                f.left = 16'(l);
                f.right = 16'(r);
                frames_due.push_back(f);
            end
        endcase
    endfunction

    function void check_frame(logic [15:0] al, logic [15:0] ar, logic ac);
        t_mix_frame e;
        frames_seen++;
        if (ac) clip_count++;
        if (frames_due.size() == 0) begin
            $error("unexpected frame: out_left=%0d out_right=%0d", $signed(al), $signed(ar));
            errors++;
            return;
        end
        e = frames_due.pop_front();
        if (al !== e.left) begin
            $error("out_left: expected %0d, actual %0d", e.left, $signed(al));
            errors++;
        end
        if (ar !== e.right) begin
            $error("out_right: expected %0d, actual %0d", e.right, $signed(ar));
            errors++;
        end
        if (ac !== e.clip) begin
            $error("clipped: expected %0d, actual %0d", e.clip, ac);
            errors++;
        end
    endfunction
endclass

module tb_sample_voice_mixer;

    // A tick walks all eight voices; the limits below allow a generous margin
    // on top of that and of the longest receiver hold-off.
    localparam int DRAIN_CYCLES = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF_CYCLES = 600;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata;  // opcode, address, pcm_word, effect_id,
                                 // frame_count, stereo, music_left, music_right
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;  // out_left, out_right
    logic         m_axis_tuser;  // clipped
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [18:0]  i_cfg_wdata;

    sample_voice_mixer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    mix_scoreboard sb;

    // Control knobs shared between the stimulus and the receiver process.
    bit  rx_idle_on;     // random receiver stalls allowed
    bit  rx_hold_req;    // request one long receiver hold-off
    bit  tx_idle_on;     // random sender gaps allowed
    int  idle_cycles;    // cycles since the last accepted item on either side
    int  sent_items;
    int  tick_items;

    // Addresses up to this bound hold the sample library built below; every
    // descriptor points into written memory so no unwritten word is ever read.
    localparam int LIB_WORDS = 512;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Watchdog: counts cycles without any handshake.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Output side: check each accepted frame at the rising edge, then drive
    // tready at the falling edge with random stall bursts and one long hold.
    initial begin
        int burst;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 9);
                m_axis_tready = 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_frame(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser);
    end

    // Sends one item; waits for acceptance and notes it in the scoreboard.
    task automatic send_item(logic [1:0] op, logic [17:0] addr, logic signed [15:0] pcm,
                             logic signed [8:0] eid, logic [18:0] nfr, logic st,
                             logic signed [15:0] ml, logic signed [15:0] mr);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {7'd0, mr, ml, st, nfr, eid, pcm, addr, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(op, addr, pcm, eid, nfr, st, ml, mr);
        sent_items++;
        if (op == OP_TICK) tick_items++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic put_word(logic [17:0] addr, logic signed [15:0] w);
        send_item(OP_PCM, addr, w, 9'($urandom), 19'($urandom), 1'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic put_desc(logic signed [8:0] eid, logic [17:0] base, logic [18:0] nfr,
                            logic st);
        send_item(OP_DESC, base, 16'($urandom), eid, nfr, st,
                  16'($urandom), 16'($urandom));
    endtask

    task automatic fire(logic signed [8:0] eid);
        send_item(OP_TRIG, 18'($urandom), 16'($urandom), eid, 19'($urandom), 1'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic tick(logic signed [15:0] ml, logic signed [15:0] mr);
        send_item(OP_TICK, 18'($urandom), 16'($urandom), 9'($urandom), 19'($urandom),
                  1'($urandom), ml, mr);
    endtask

    // Waits until every predicted frame has arrived, then lets the block settle
    // so a configuration write never lands while it is busy.
    task automatic drain();
        while (sb.frames_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [18:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // A random descriptor whose whole footprint stays inside the library.
    // Lengths straddle the fade window, many long enough for a fade plateau; a rare one is zero to three frames.
    task automatic random_desc(logic signed [8:0] eid);
        int nfr;
        int st;
        int span;
        st = $urandom_range(0, 1);
        nfr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3)
                                         : $urandom_range(1, st ? 250 : 500);
        span = st ? 2 * nfr : nfr;
        put_desc(eid, 18'($urandom_range(0, LIB_WORDS - span)), 19'(nfr), st[0]);
    endtask

    // Random effect id: mostly a valid slot of either sign, sometimes too large.
    function automatic logic signed [8:0] rand_eid();
        int m;
        m = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 255) : $urandom_range(0, 15);
        return ($urandom_range(0, 1) == 1) ? 9'(-m) : 9'(m);
    endfunction

    function automatic logic signed [15:0] rand_music();
        case ($urandom_range(0, 4))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int kind;
        sb = new();
        rx_idle_on = 1'b0;
        rx_hold_req = 1'b0;
        tx_idle_on = 1'b0;
        idle_cycles = 0;
        sent_items = 0;
        tick_items = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_VOICE_GAIN;
        i_cfg_wdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part: ticks before anything is loaded, music at the rails,
        // writes beyond the library, a bad descriptor slot, empty and
        // out-of-range triggers, the retrigger guard, and a full-scale voice.
        tick(16'sh7FFF, 16'sh8000);
        tick(16'sh8000, 16'sh7FFF);
        put_word(18'h3FFFF, 16'sh7FFF);
        put_word(18'd0, 16'sh7FFF);
        put_word(18'd1, 16'sh8000);
        put_desc(9'sd16, 18'd0, 19'd5, 1'b0);
        put_desc(-9'sd255, 18'h3FFFF, 19'h7FFFF, 1'b1);
        fire(9'sd3);
        fire(-9'sd255);
        put_desc(-9'sd2, 18'd0, 19'd1, 1'b1);
        put_desc(9'sd15, 18'h3FFFF, 19'd1, 1'b0);
        fire(9'sd2);
        fire(-9'sd2);
        fire(9'sd15);
        tick(16'sh7FFF, 16'sh7FFF);
        tick('0, '0);
        drain();
        write_cfg(REG_VOICE_GAIN, 19'd256);
        write_cfg(REG_MUSIC_GAIN, 19'd256);
        write_cfg(REG_GUARD, 19'd0);
        put_desc(9'sd0, 18'd0, 19'd200, 1'b0);
        for (int i = 0; i < 9; i++) fire(9'sd0);
        tick(16'sh7FFF, 16'sh8000);

        // Fill the library with random words including the rails.
        for (int a = 0; a < LIB_WORDS; a++)
            put_word(18'(a), ($urandom_range(0, 7) == 0) ? rand_music() : 16'($urandom));
        for (int i = 0; i < EFFECTS; i++) random_desc(9'(i));

        // Random part in phases with different register settings.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_cfg(REG_VOICE_GAIN, (ph == 0) ? 19'd0 : (ph == 1) ? 19'd256
                                                 : 19'($urandom_range(0, 511)));
            write_cfg(REG_MUSIC_GAIN, (ph == 2) ? 19'd0 : (ph == 3) ? 19'd511
                                                 : 19'($urandom_range(0, 256)));
            write_cfg(REG_GUARD, (ph == 4) ? 19'h7FFFF : (ph == 3) ? 19'd0
                                            : 19'($urandom_range(0, 300)));
            rx_idle_on = (ph < 5);
            tx_idle_on = (ph < 5);
            if (ph == 2) rx_hold_req = 1'b1;
            for (int n = 0; n < 210; n++) begin
                kind = $urandom_range(0, 19);
                if (kind < 12) tick(rand_music(), rand_music());
                else if (kind < 16) fire(rand_eid());
                else if (kind < 18) random_desc(rand_eid());
                else put_word(18'($urandom_range(0, LIB_WORDS - 1)), 16'($urandom));
            end
            // Pause the sender until the block has delivered everything.
            if (ph == 1) begin
                while (sb.frames_due.size() != 0) @(negedge i_clk);
            end
        end

        drain();
        $display("Sent %0d items (%0d ticks); checked %0d frames, %0d of them clipped.",
                 sent_items, tick_items, sb.frames_seen, sb.clip_count);
        if (sb.errors == 0 && sb.frames_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
